[src/zlhs_pkg.sv]
// ----------------------------------------------------------------------------
// zlhs_pkg: shared types and constants of the ZIP local header name scanner
// Holds the result record, result kind codes, scan phase codes and header
// offsets used by the scanner core, the result queue and the top level.
// ----------------------------------------------------------------------------
package zlhs_pkg;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Scan phases
    localparam logic [1:0] PH_SCAN   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_NAME   = 2'd2;

    // Local file header signature, oldest byte in the top bits
    localparam logic [31:0] HDR_SIGNATURE = 32'h504B_0304;

    // Header offsets
    localparam logic [4:0] OFS_AFTER_SIG = 5'd4;
    localparam logic [4:0] OFS_LEN_LO    = 5'd26;
    localparam logic [4:0] OFS_LEN_HI    = 5'd27;
    localparam logic [4:0] OFS_HDR_LAST  = 5'd29;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        name_end;
        logic [15:0] headers_found;
    } result_t;

    // Up to two results produced by one input byte, packed from slot 0
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } step_t;

endpackage

[src/zlhs_intf.sv]
// ----------------------------------------------------------------------------
// zlhs channel interfaces
// Valid/ready channels for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
interface zlhs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface zlhs_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] value;
    logic        name_end;
    logic [15:0] headers_found;

    modport source (output valid, output kind, output value, output name_end,
                    output headers_found, input ready);
    modport sink   (input valid, input kind, input value, input name_end,
                    input headers_found, output ready);
endinterface

[src/zlhs_core.sv]
// ----------------------------------------------------------------------------
// zlhs_core: signature scan and header walk
// Updates the scan state for one accepted byte and emits up to two results.
// ----------------------------------------------------------------------------
module zlhs_core
    import zlhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output step_t      step
);

    logic [23:0] recent_reg, recent_next;
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  offset_reg, offset_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] count_reg, count_next;

    logic        a_valid;
    result_t     a_res;
    result_t     sum_res;
    logic [31:0] window;
    logic [15:0] name_len;

    always_comb
    begin
        recent_next = recent_reg;
        phase_next  = phase_reg;
        offset_next = offset_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        a_valid     = 1'b0;
        a_res       = '0;
        sum_res     = '0;
        window      = {recent_reg, data_byte};
        name_len    = {data_byte, len_lo_reg};

        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == OFS_LEN_LO)
                    begin
                        len_lo_next = data_byte;
                    end
                    else if (offset_reg == OFS_LEN_HI)
                    begin
                        remain_next           = name_len;
                        a_valid               = 1'b1;
                        a_res.kind            = KIND_HEADER;
                        a_res.value           = name_len;
                        a_res.name_end        = (name_len == 16'd0);
                        a_res.headers_found   = count_reg;
                    end
                    if (offset_reg >= OFS_HDR_LAST)
                    begin
                        phase_next  = (remain_reg == 16'd0) ? PH_SCAN : PH_NAME;
                        recent_next = '0;
                        offset_next = '0;
                    end
                    else
                    begin
                        offset_next = offset_reg + 5'd1;
                    end
                end
                PH_NAME:
                begin
                    a_valid             = 1'b1;
                    a_res.kind          = KIND_NAME;
                    a_res.value         = {8'd0, data_byte};
                    a_res.name_end      = (remain_reg <= 16'd1);
                    a_res.headers_found = count_reg;
                    remain_next         = remain_reg - 16'd1;
                    if (remain_reg <= 16'd1)
                    begin
                        remain_next = '0;
                        phase_next  = PH_SCAN;
                        recent_next = '0;
                    end
                end
                default:
                begin
                    if (window == HDR_SIGNATURE)
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 16'd1;
                        end
                        phase_next  = PH_HEADER;
                        offset_next = OFS_AFTER_SIG;
                        len_lo_next = '0;
                        remain_next = '0;
                        recent_next = '0;
                    end
                    else
                    begin
                        phase_next  = PH_SCAN;
                        recent_next = window[23:0];
                    end
                end
            endcase

            sum_res.kind          = KIND_SUMMARY;
            sum_res.value         = count_next;
            sum_res.name_end      = 1'b0;
            sum_res.headers_found = count_next;

            // End of file: start over for the next one
            if (final_byte)
            begin
                recent_next = '0;
                phase_next  = PH_SCAN;
                offset_next = '0;
                len_lo_next = '0;
                remain_next = '0;
                count_next  = '0;
            end
        end

        step.push0 = take && (a_valid || final_byte);
        step.push1 = take && a_valid && final_byte;
        step.res0  = a_valid ? a_res : sum_res;
        step.res1  = sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            phase_reg  <= PH_SCAN;
            offset_reg <= '0;
            len_lo_reg <= '0;
            remain_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            recent_reg <= recent_next;
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    // Name bytes are counted down and never underflow past zero
    a_name_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NAME) |-> (remain_reg != 16'd0))
        else $error("zlhs_core: name phase with nothing left");

    // The header count only steps by one, holds, or clears on a final byte
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !final_byte) |=>
            (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 16'd1))
        else $error("zlhs_core: header count jumped");

    // The header walk stays inside the header
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (offset_reg >= OFS_AFTER_SIG && offset_reg <= OFS_HDR_LAST))
        else $error("zlhs_core: header offset out of range");
`endif

endmodule

[src/zlhs_rqueue.sv]
// ----------------------------------------------------------------------------
// zlhs_rqueue: result queue
// Small register queue taking up to two results per cycle, handing out one.
// ----------------------------------------------------------------------------
module zlhs_rqueue
    import zlhs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  step_t   step,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_1;
    logic                pop;
    logic [QCNT_W-1:0]   n_push;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    // Two free slots are needed to take any byte
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign wr_ptr_1  = wr_ptr_reg + QPTR_W'(1);
    assign n_push    = QCNT_W'(step.push0) + QCNT_W'(step.push1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + n_push - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (step.push0)
        begin
            mem_reg[wr_ptr_reg] <= step.res0;
        end
        if (step.push1)
        begin
            mem_reg[wr_ptr_1] <= step.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        step.push0 |-> (count_reg <= QCNT_W'(QUEUE_DEPTH - 2)))
        else $error("zlhs_rqueue: push without room");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        step.push1 |-> step.push0)
        else $error("zlhs_rqueue: slot 1 written without slot 0");

    // Pointer gap wraps at the queue depth, so a full queue shows a gap of zero
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> ((wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg)))
        else $error("zlhs_rqueue: fill count out of step with pointers");
`endif

endmodule

[src/zip_local_header_name_scanner_unit.sv]
// ----------------------------------------------------------------------------
// zip_local_header_name_scanner_unit: ZIP local file header name scanner
// Scans a byte stream for local file headers and reports each file name.
// ----------------------------------------------------------------------------
// The block takes one file byte per request and scans for the local header
// signature 50 4B 03 04. On a hit it counts the header (saturating at 65535),
// walks to header offset 26, reads the 16-bit little-endian name length and
// reports a header result (kind 0) with that length when offset 27 arrives;
// name_end is set there if the name is empty. Each name byte is then
// reported as kind 1, the last one with name_end set, and scanning resumes
// at the byte right after the name. A byte marked final_byte adds a summary
// (kind 2) with the header count after its own result, and the block then
// starts over for the next file; an unfinished header or name is dropped.
// One byte is taken per clock while the queue has room; the scan state
// updates as each byte is taken, and results go into a four-entry register
// queue whose head drives the result port. A byte is taken whenever two
// queue slots are free, so the rate is one byte per cycle as long as
// results are drained one per cycle; only the final byte of a file makes
// two results.
// ----------------------------------------------------------------------------
module zip_local_header_name_scanner_unit
    import zlhs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    zlhs_byte_if.sink        scan,
    zlhs_result_if.source    report
);

    step_t   step;
    logic    room;
    logic    take;
    result_t head;

    // Accept a byte only while the queue can hold both possible results
    assign scan.ready = room;
    assign take       = scan.valid && room;

    zlhs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (scan.data_byte),
        .final_byte (scan.final_byte),
        .step       (step)
    );

    // Hold results until the sink takes them
    zlhs_rqueue u_rqueue (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .room      (room),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .out_res   (head)
    );

    assign report.kind          = head.kind;
    assign report.value         = head.value;
    assign report.name_end      = head.name_end;
    assign report.headers_found = head.headers_found;

endmodule
